[hdl/plti_pkg.sv]
// Shared types and constants for the piecewise linear table interpolator.
// Used by the controller, the datapath and the top level.
package plti_pkg;

    // Table geometry
    localparam int MAX_POINTS = 64;
    localparam int NUM_TABLES = 3;
    localparam int DEPTH      = NUM_TABLES * MAX_POINTS;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int PT_W       = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

    // Port field widths
    localparam int DATA_W   = 32;
    localparam int TAB_W    = 2;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int NUM_CFG  = 3;
    localparam int CFG_IDX_W = 2;
    localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

    // Division: one quotient bit per cycle over the 64-bit product
    localparam int DIV_STEPS = 2 * DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        REG_BELOW  = 2'd0,
        REG_INSIDE = 2'd1,
        REG_ABOVE  = 2'd2
    } t_region;

    typedef enum logic [1:0] {
        RD_FIRST,
        RD_LAST,
        RD_ONE,
        RD_NEXT
    } t_rd_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_CHK0,
        S_CHKN,
        S_SCAN,
        S_PREP,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic    accept;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    set_lo;
        logic    set_hi;
        logic    res_first;
        logic    res_last;
        logic    i_init;
        logic    i_inc;
        logic    prep;
        logic    mul;
        logic    div_step;
        logic    res_interp;
        logic    load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic query_ok;
        logic below;
        logic at_top;
        logic scan_go;
        logic div_last;
        logic out_free;
    } t_sts;

    // Last valid point index from a programmed count, count clamped to [2, MAX_POINTS]
    function automatic logic [PT_W-1:0] last_index(input logic [CNT_W-1:0] cnt);
        logic [PT_W-1:0] res;
        if (32'(cnt) < 2) begin
            res = PT_W'(1);
        end else if (32'(cnt) > MAX_POINTS) begin
            res = PT_W'(MAX_POINTS - 1);
        end else begin
            res = PT_W'(32'(cnt) - 1);
        end
        return res;
    endfunction

endpackage

[hdl/plti_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module plti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

[hdl/plti_ctrl.sv]
// Controller state machine: sequences the table search, multiply and divide.
// Depends on plti_pkg.
module plti_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  plti_pkg::t_sts i_sts,
    output plti_pkg::t_cmd o_cmd
);
    import plti_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.query_ok) begin
                    n_state = S_RD0;
                end
            end
            S_RD0:  n_state = S_CHK0;
            S_CHK0: n_state = i_sts.below ? S_OUT : S_CHKN;
            S_CHKN: n_state = i_sts.at_top ? S_OUT : S_SCAN;
            S_SCAN: begin
                if (!i_sts.scan_go) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:  n_state = S_OUT;
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.rd_sel = RD_FIRST;
        o_in_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            S_RD0: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_FIRST;
            end
            S_CHK0: begin
                o_cmd.set_lo = 1'b1;
                if (i_sts.below) begin
                    o_cmd.res_first = 1'b1;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LAST;
                end
            end
            S_CHKN: begin
                if (i_sts.at_top) begin
                    o_cmd.res_last = 1'b1;
                end else begin
                    o_cmd.i_init = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_ONE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_go) begin
                    o_cmd.set_lo = 1'b1;
                    o_cmd.i_inc  = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_NEXT;
                end else begin
                    o_cmd.set_hi = 1'b1;
                end
            end
            S_PREP: o_cmd.prep = 1'b1;
            S_MUL:  o_cmd.mul = 1'b1;
            S_DIV:  o_cmd.div_step = 1'b1;
            S_FIN:  o_cmd.res_interp = 1'b1;
            S_OUT:  o_cmd.load_out = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[hdl/plti_dp.sv]
// Datapath: count registers, table RAMs, bracket registers, multiplier,
// restoring divider and output register. Depends on plti_pkg and plti_ram.
module plti_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_valid,
    input  logic [plti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plti_pkg::CNT_W-1:0]     i_cfg_data,
    // input word fields
    input  logic                           i_op,
    input  logic [plti_pkg::TAB_W-1:0]     i_table_select,
    input  logic [plti_pkg::IDX_W-1:0]     i_point_index,
    input  logic [plti_pkg::DATA_W-1:0]    i_energy,
    input  logic [plti_pkg::DATA_W-1:0]    i_loss_value,
    // control
    input  plti_pkg::t_cmd                 i_cmd,
    output plti_pkg::t_sts                 o_sts,
    // result word
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [plti_pkg::DATA_W-1:0]    o_interpolated,
    output logic [1:0]                     o_region
);
    import plti_pkg::*;

    // Point counts, one per table register
    logic [CNT_W-1:0] r_points [NUM_CFG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CFG; k++) begin
                r_points[k] <= CNT_RESET;
            end
        end else if (i_cfg_valid && (32'(i_cfg_index) < NUM_CFG)) begin
            r_points[i_cfg_index] <= i_cfg_data;
        end
    end

    // Input decode
    logic              table_ok;
    logic              idx_ok;
    logic [ADDR_W-1:0] in_base;
    logic [CNT_W-1:0]  in_cnt;

    assign table_ok = 32'(i_table_select) < NUM_TABLES;
    assign idx_ok   = 32'(i_point_index) < MAX_POINTS;
    assign in_base  = ADDR_W'(32'(i_table_select) * MAX_POINTS);
    assign in_cnt   = (32'(i_table_select) < NUM_CFG) ?
                      r_points[CFG_IDX_W'(i_table_select)] : CNT_RESET;

    assign o_sts.query_ok = (i_op == OP_QUERY) && table_ok;

    // Query context
    logic [ADDR_W-1:0] r_base;
    logic [PT_W-1:0]   r_last;
    logic [DATA_W-1:0] r_energy;
    logic [PT_W-1:0]   r_i;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_base   <= in_base;
            r_last   <= last_index(in_cnt);
            r_energy <= i_energy;
        end
        if (i_cmd.i_init) begin
            r_i <= PT_W'(1);
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + PT_W'(1);
        end
    end

    // Table memories
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_x;
    logic [DATA_W-1:0] rd_y;

    assign wr_en   = i_cmd.accept && (i_op == OP_LOAD) && table_ok && idx_ok;
    assign wr_addr = in_base + ADDR_W'(i_point_index);

    always_comb begin
        case (i_cmd.rd_sel)
            RD_FIRST: rd_addr = r_base;
            RD_LAST:  rd_addr = r_base + ADDR_W'(r_last);
            RD_ONE:   rd_addr = r_base + ADDR_W'(1);
            RD_NEXT:  rd_addr = r_base + ADDR_W'(r_i) + ADDR_W'(1);
            default:  rd_addr = r_base;
        endcase
    end

    plti_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_x_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_energy),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_x)
    );

    plti_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_y_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_loss_value),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_y)
    );

    // Search compares against the word just read
    assign o_sts.below   = r_energy < rd_x;
    assign o_sts.at_top  = r_energy >= rd_x;
    assign o_sts.scan_go = (r_i != r_last) && (rd_x <= r_energy);

    // Bracketing points
    logic [DATA_W-1:0] r_xlo, r_ylo, r_xhi, r_yhi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_lo) begin
            r_xlo <= rd_x;
            r_ylo <= rd_y;
        end
        if (i_cmd.set_hi) begin
            r_xhi <= rd_x;
            r_yhi <= rd_y;
        end
    end

    // Operand prep, multiply, then restoring divide one bit a cycle
    logic [DATA_W-1:0]    r_mag, r_t, r_dx;
    logic                 r_neg;
    logic [DATA_W-1:0]    r_rem;
    logic [2*DATA_W-1:0]  r_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W:0]      div_shift;
    logic                 div_ge;

    assign div_shift = {r_rem, r_quo[2*DATA_W-1]};
    assign div_ge    = div_shift >= {1'b0, r_dx};
    assign o_sts.div_last = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_t   <= r_energy - r_xlo;
            r_dx  <= r_xhi - r_xlo;
            r_neg <= r_yhi < r_ylo;
            r_mag <= (r_yhi < r_ylo) ? (r_ylo - r_yhi) : (r_yhi - r_ylo);
        end
        if (i_cmd.mul) begin
            r_quo <= r_mag * r_t;
            r_rem <= '0;
            r_cnt <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? DATA_W'(div_shift - {1'b0, r_dx}) : div_shift[DATA_W-1:0];
            r_quo <= {r_quo[2*DATA_W-2:0], div_ge};
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

    // Result select
    logic [DATA_W-1:0] r_res;
    t_region           r_region;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_first || i_cmd.res_last) begin
            r_res    <= rd_y;
            r_region <= i_cmd.res_first ? REG_BELOW : REG_ABOVE;
        end else if (i_cmd.res_interp) begin
            r_res    <= r_neg ? (r_ylo - r_quo[DATA_W-1:0]) : (r_ylo + r_quo[DATA_W-1:0]);
            r_region <= REG_INSIDE;
        end
    end

    // Output register
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_interpolated <= r_res;
            o_region       <= r_region;
        end
    end

endmodule

[hdl/piecewise_linear_table_interpolator.sv]
// Load word: accepted while idle, written to the table RAMs at acceptance when the table select is valid.
// Query word: below the first point the result is taken from the first point, at or
// above the last point from the last point; inside the table it passes the
// one-read-per-cycle table walk, the multiply and the 64-step divider.
// One query at a time; a finished word may wait in the output register.
// Synchronous active-low reset: counts return to 2, table RAM contents undefined.
module piecewise_linear_table_interpolator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_op,
    input  logic [plti_pkg::TAB_W-1:0]     i_table_select,
    input  logic [plti_pkg::IDX_W-1:0]     i_point_index,
    input  logic [plti_pkg::DATA_W-1:0]    i_energy,
    input  logic [plti_pkg::DATA_W-1:0]    i_loss_value,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [plti_pkg::DATA_W-1:0]    o_interpolated,
    output logic [1:0]                     o_region,
    // configuration channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [plti_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plti_pkg::CNT_W-1:0]     i_cfg_data
);
    import plti_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    plti_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    plti_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_table_select (i_table_select),
        .i_point_index  (i_point_index),
        .i_energy       (i_energy),
        .i_loss_value   (i_loss_value),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_interpolated (o_interpolated),
        .o_region       (o_region)
    );

endmodule
